/* hw/rtl/bts_pkg.sv */
// Shared types and constants for the bilinear texture sampler.
package bts_pkg;

	localparam int CHAN_BITS  = 8;
	localparam int NUM_CHAN   = 3;
	localparam int TEXEL_BITS = CHAN_BITS * NUM_CHAN;
	localparam int COORD_BITS = 16;
	localparam int INDEX_BITS = 16;
	localparam int CFG_BITS   = 9;
	localparam int OUT_BITS   = 16;

	// Item opcodes carried on the action port.
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Configuration register indexes.
	localparam logic REG_TEX_WIDTH  = 1'b0;
	localparam logic REG_TEX_HEIGHT = 1'b1;

	// Tag that travels with each texel read from the sequencer to the blender.
	typedef struct packed {
		logic valid;
		logic hi_x;
		logic hi_y;
	} bts_tap_t;

endpackage

/* hw/rtl/bts_ram.sv */
// Generic single-port RAM with registered read data.
module bts_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* hw/rtl/bts_blend.sv */
// Per-channel bilinear blend lanes: row interpolation, then column interpolation.
module bts_blend import bts_pkg::*; #(
	parameter int WEIGHT_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [WEIGHT_BITS-1:0] fx,
	input  logic [WEIGHT_BITS-1:0] fy,
	input  bts_tap_t               tap,
	input  logic [TEXEL_BITS-1:0]  texel,
	output logic [OUT_BITS-1:0]    red_out,
	output logic [OUT_BITS-1:0]    green_out,
	output logic [OUT_BITS-1:0]    blue_out,
	output logic                   done
);

	localparam int WB = WEIGHT_BITS;
	localparam logic [WB:0] ONE = {1'b1, {WB{1'b0}}};

	logic                row_vld_s1;
	logic                hi_y_s1;
	logic                done_q;
	logic [WB:0]         wy;
	logic [OUT_BITS-1:0] res_q [NUM_CHAN];

	// The vertical weight is shared by all lanes.
	assign wy = hi_y_s1 ? {1'b0, fy} : ONE - {1'b0, fy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_s1 <= 1'b0;
			hi_y_s1    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			row_vld_s1 <= tap.valid & tap.hi_x;
			hi_y_s1    <= tap.hi_y;
			done_q     <= row_vld_s1 & hi_y_s1;
		end
	end

	for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_lane
		logic [CHAN_BITS-1:0] chan;
		logic [WB:0]          wx;
		logic [WB+8:0]        prod_a;
		logic [WB+8:0]        row_q;
		logic [WB+8:0]        hrow_s1;
		logic [2*WB+9:0]      prod_b;
		logic [2*WB+9:0]      acc_q;
		logic [2*WB+9:0]      total;

		assign chan   = texel[CHAN_BITS*(NUM_CHAN-1-ch) +: CHAN_BITS];
		assign wx     = tap.hi_x ? {1'b0, fx} : ONE - {1'b0, fx};
		assign prod_a = (WB+9)'(wx) * (WB+9)'(chan);
		assign prod_b = (2*WB+10)'(wy) * (2*WB+10)'(hrow_s1);
		assign total  = acc_q + prod_b;

		// The left texel of a row parks in row_q until its right neighbor arrives.
		always_ff @(posedge clk) begin
			if (tap.valid) begin
				if (!tap.hi_x) begin
					row_q <= prod_a;
				end else begin
					hrow_s1 <= row_q + prod_a;
				end
			end
			if (row_vld_s1) begin
				if (!hi_y_s1) begin
					acc_q <= prod_b;
				end else begin
					res_q[ch] <= total[2*WB+7 -: OUT_BITS];
				end
			end
		end
	end

	assign red_out   = res_q[0];
	assign green_out = res_q[1];
	assign blue_out  = res_q[2];
	assign done      = done_q;

endmodule

/* hw/rtl/bilinear_texture_sampler.sv */
// Top level of the bilinear texture sampler: sequencer, shared multiplier and texel memory.
//
//   channel   direction  handshake             word
//   -------   ---------  --------------------  ------------------------------------------
//   item      in         start & !busy         action, texel_index, red/green/blue_in,
//                                              coord_u, coord_v
//   result    out        done (one cycle)      red_out, green_out, blue_out
//   config    in         cfg_we                cfg_index, cfg_wdata
//
// A write word goes straight into the texel memory in the cycle it is accepted; busy stays
// low, so writes can stream at one per cycle while no sample word is in progress. A sample
// word keeps busy high while the shared multiplier forms u times width, v times height and
// top row times width, four reads go through the single memory port (the bottom row base is
// formed by the multiplier during the first read), and a two-stage blend runs. The result
// strobe done comes in the drain state, and the next word can be taken in the cycle after it.
// The result is shown for exactly one cycle; the receiver cannot stall it.
// Reset clears the sequencer and sets both dimension registers to 256. The texel memory is
// not cleared: reading a texel that was never written returns whatever the RAM holds.
module bilinear_texture_sampler import bts_pkg::*; #(
	parameter int MAX_WIDTH   = 256,
	parameter int MAX_HEIGHT  = 256,
	parameter int WEIGHT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  action,
	input  logic [INDEX_BITS-1:0] texel_index,
	input  logic [CHAN_BITS-1:0]  red_in,
	input  logic [CHAN_BITS-1:0]  green_in,
	input  logic [CHAN_BITS-1:0]  blue_in,
	input  logic [COORD_BITS-1:0] coord_u,
	input  logic [COORD_BITS-1:0] coord_v,
	output logic                  done,
	output logic [OUT_BITS-1:0]   red_out,
	output logic [OUT_BITS-1:0]   green_out,
	output logic [OUT_BITS-1:0]   blue_out,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_BITS-1:0]   cfg_wdata
);

	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int PROD_W  = COORD_BITS + DIM_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_U,
		S_MUL_V,
		S_MUL_Y0,
		S_FETCH,
		S_DRAIN
	} state_t;

	state_t                 state_q;
	logic [1:0]             step_q;
	bts_tap_t               tap_s1;
	logic [CFG_BITS-1:0]    cfg_w_q;
	logic [CFG_BITS-1:0]    cfg_h_q;

	logic [COORD_BITS-1:0]  u_q;
	logic [COORD_BITS-1:0]  v_q;
	logic [DIM_W-1:0]       x0_q;
	logic [DIM_W-1:0]       x1_q;
	logic [DIM_W-1:0]       y0_q;
	logic [DIM_W-1:0]       y1_q;
	logic [WEIGHT_BITS-1:0] fx_q;
	logic [WEIGHT_BITS-1:0] fy_q;
	logic [ADDR_W-1:0]      base0_q;
	logic [ADDR_W-1:0]      base1_q;

	logic [DIM_W-1:0]       w_eff;
	logic [DIM_W-1:0]       h_eff;
	logic [COORD_BITS-1:0]  mul_a;
	logic [DIM_W-1:0]       mul_b;
	logic [PROD_W-1:0]      mul_p;
	logic [DIM_W-1:0]       pos;
	logic [DIM_W-1:0]       pos_next;
	logic [WEIGHT_BITS-1:0] frac;
	logic                   at_edge;

	logic                   accept;
	logic [ADDR_W+15:0]     idx_wide;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_addr;
	logic [ADDR_W-1:0]      rd_addr;
	logic [TEXEL_BITS-1:0]  ram_rdata;
	logic                   blend_done;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// A zero dimension behaves as one, and anything beyond the memory geometry is capped.
	assign w_eff = (cfg_w_q == '0) ? DIM_W'(1) :
	               (32'(cfg_w_q) > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(cfg_w_q);
	assign h_eff = (cfg_h_q == '0) ? DIM_W'(1) :
	               (32'(cfg_h_q) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : DIM_W'(cfg_h_q);

	// The one multiplier of the sequencer (the blend lanes have their own). It scales both
	// coordinates and then forms both row base addresses, one product per cycle under the sequencer.
	always_comb begin
		unique case (state_q)
			S_MUL_U:  mul_a = u_q;
			S_MUL_V:  mul_a = v_q;
			S_MUL_Y0: mul_a = COORD_BITS'(y0_q);
			default:  mul_a = COORD_BITS'(y1_q);
		endcase
	end
	assign mul_b = (state_q == S_MUL_V) ? h_eff : w_eff;
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// The integer part of the scaled coordinate is the texel position and the bits just
	// below the binary point are the blend fraction. On the last column or row the neighbor
	// folds back onto the texel itself and gets no weight.
	assign pos      = mul_p[COORD_BITS +: DIM_W];
	assign at_edge  = ((DIM_W+1)'(pos) + (DIM_W+1)'(1)) >= (DIM_W+1)'(mul_b);
	assign pos_next = at_edge ? pos : pos + DIM_W'(1);
	assign frac     = at_edge ? '0 : mul_p[COORD_BITS-1 -: WEIGHT_BITS];

	// Write words go to the memory in the cycle they are accepted; out-of-range
	// addresses are dropped.
	assign idx_wide = {{ADDR_W{1'b0}}, texel_index};
	assign ram_we   = accept && (action == ACT_WRITE) &&
	                  (idx_wide < (ADDR_W+16)'(DEPTH));

	// Texels are read in the order top-left, top-right, bottom-left, bottom-right.
	assign rd_addr  = (step_q[1] ? base1_q : base0_q) +
	                  ADDR_W'(step_q[0] ? x1_q : x0_q);
	assign ram_addr = (state_q == S_FETCH) ? rd_addr : idx_wide[ADDR_W-1:0];

	bts_ram #(
		.WIDTH (TEXEL_BITS),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata({red_in, green_in, blue_in}),
		.rdata(ram_rdata)
	);

	bts_blend #(
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.fx       (fx_q),
		.fy       (fy_q),
		.tap      (tap_s1),
		.texel    (ram_rdata),
		.red_out  (red_out),
		.green_out(green_out),
		.blue_out (blue_out),
		.done     (blend_done)
	);

	assign done = blend_done;

	// Sequencer, read tag pipeline and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			tap_s1  <= '0;
			cfg_w_q <= CFG_BITS'(256);
			cfg_h_q <= CFG_BITS'(256);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TEX_WIDTH:  cfg_w_q <= cfg_wdata;
					REG_TEX_HEIGHT: cfg_h_q <= cfg_wdata;
				endcase
			end

			// The tag is registered like the read data, so both arrive in the cycle after the address.
			tap_s1.valid <= (state_q == S_FETCH);
			tap_s1.hi_x  <= step_q[0];
			tap_s1.hi_y  <= step_q[1];

			unique case (state_q)
				S_IDLE: begin
					if (start && (action == ACT_SAMPLE)) begin
						state_q <= S_MUL_U;
					end
				end
				S_MUL_U:  state_q <= S_MUL_V;
				S_MUL_V:  state_q <= S_MUL_Y0;
				S_MUL_Y0: begin
					step_q  <= '0;
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (blend_done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sample operands and the products taken off the shared multiplier.
	always_ff @(posedge clk) begin
		if (accept) begin
			u_q <= coord_u;
			v_q <= coord_v;
		end
		if (state_q == S_MUL_U) begin
			x0_q <= pos;
			x1_q <= pos_next;
			fx_q <= frac;
		end
		if (state_q == S_MUL_V) begin
			y0_q <= pos;
			y1_q <= pos_next;
			fy_q <= frac;
		end
		if (state_q == S_MUL_Y0) begin
			base0_q <= mul_p[ADDR_W-1:0];
		end
		if ((state_q == S_FETCH) && (step_q == 2'd0)) begin
			base1_q <= mul_p[ADDR_W-1:0];
		end
	end

	// An accepted sample always starts the coordinate multiply in the next cycle.
	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == ACT_SAMPLE)) |=> (state_q == S_MUL_U))
		else $error("sample word did not start the sequencer");

	// Each sample yields one result strobe, which only comes while the sequencer drains.
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == S_DRAIN))
		else $error("result strobe outside the drain state");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// Texel reads are only tagged while the fetch or drain phase is running.
	a_tap_in_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		tap_s1.valid |-> ((state_q == S_FETCH) || (state_q == S_DRAIN)))
		else $error("texel read tag outside the fetch phase");

endmodule

/* tb/sv/bilinear_texture_sampler_tb.sv */
// Self-checking testbench for the bilinear texture sampler: directed and random texel writes and samples.
module bilinear_texture_sampler_tb;
	import bts_pkg::*;

	localparam int MAX_W         = 256;
	localparam int MAX_H         = 256;
	localparam int WGT_BITS      = 8;
	localparam int TEX_DEPTH     = MAX_W * MAX_H;
	// Longer than a sample word keeps the block busy, to make sure it is quiet.
	localparam int SETTLE_CYCLES = 14;
	localparam int ITEM_TARGET   = 1900;

	// One entry of the stimulus plan: either a dimension register write or an item word.
	typedef struct packed {
		logic                  is_cfg;
		logic                  reg_sel;
		logic [CFG_BITS-1:0]   reg_val;
		logic                  act;
		logic [INDEX_BITS-1:0] index;
		logic [CHAN_BITS-1:0]  r;
		logic [CHAN_BITS-1:0]  g;
		logic [CHAN_BITS-1:0]  b;
		logic [COORD_BITS-1:0] u;
		logic [COORD_BITS-1:0] v;
	} tex_op_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] r;
		logic [OUT_BITS-1:0] g;
		logic [OUT_BITS-1:0] b;
	} pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  action = ACT_WRITE;
	logic [INDEX_BITS-1:0] texel_index = '0;
	logic [CHAN_BITS-1:0]  red_in = '0;
	logic [CHAN_BITS-1:0]  green_in = '0;
	logic [CHAN_BITS-1:0]  blue_in = '0;
	logic [COORD_BITS-1:0] coord_u = '0;
	logic [COORD_BITS-1:0] coord_v = '0;
	logic                  done;
	logic [OUT_BITS-1:0]   red_out;
	logic [OUT_BITS-1:0]   green_out;
	logic [OUT_BITS-1:0]   blue_out;
	logic                  cfg_we = 1'b0;
	logic                  cfg_index = REG_TEX_WIDTH;
	logic [CFG_BITS-1:0]   cfg_wdata = '0;

	// Stimulus plan, filled up front, and the word that is currently on the item ports.
	tex_op_t texture_ops[$];
	tex_op_t cur_op;
	tex_op_t nxt_op;
	logic    nxt_start;
	logic    nxt_we;

	// Predictor state: a copy of the texel memory and of the two dimension registers.
	logic [TEXEL_BITS-1:0] texel_mirror [TEX_DEPTH];
	logic [CFG_BITS-1:0]   mirror_w = 9'd256;
	logic [CFG_BITS-1:0]   mirror_h = 9'd256;
	pixel_t                expected_pixels[$];
	pixel_t                want_px;

	// Planning state: which texels the plan has written so far, and the dimensions it set.
	bit                    painted [TEX_DEPTH];
	logic [CFG_BITS-1:0]   plan_w = 9'd256;
	logic [CFG_BITS-1:0]   plan_h = 9'd256;

	int gap_left     = 0;
	int burst_left   = 0;
	int idle_cycles  = 0;
	bit feed_empty   = 1'b0;
	int n_items      = 0;
	int n_samples    = 0;
	int n_texel_wr   = 0;
	int n_results    = 0;
	int n_cfg_writes = 0;
	int n_errors     = 0;
	int drain_wait;

	bilinear_texture_sampler #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H),
		.WEIGHT_BITS(WGT_BITS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.texel_index(texel_index),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.coord_u    (coord_u),
		.coord_v    (coord_v),
		.done       (done),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always #4 clk = ~clk;

	// Every failure goes through here: one line, one count.
	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		n_errors++;
	endtask

	// A dimension register of zero acts as one, and anything past the maximum acts as the maximum.
	function automatic int unsigned eff_dim(input logic [CFG_BITS-1:0] raw, input int unsigned limit);
		if (raw == '0)
			return 1;
		if (32'(raw) > limit)
			return limit;
		return 32'(raw);
	endfunction

	// Scales a 0.16 coordinate by the dimension. The integer part is the lower texel; the next
	// WGT_BITS bits are the weight of the upper one. On the last column or row the upper
	// neighbor folds onto the lower one and gets no weight.
	function automatic void split_axis(input logic [COORD_BITS-1:0] c, input int unsigned dim,
			output int unsigned lo, output int unsigned hi, output int unsigned frac);
		int unsigned scaled;
		scaled = 32'(c) * dim;
		lo = scaled >> 16;
		frac = (scaled >> (16 - WGT_BITS)) & ((1 << WGT_BITS) - 1);
		if (lo >= dim)
			lo = dim - 1;
		if (lo + 1 >= dim) begin
			hi = lo;
			frac = 0;
		end else begin
			hi = lo + 1;
		end
	endfunction

	// Row-major addresses of the four texels a sample touches, in the order
	// top-left, top-right, bottom-left, bottom-right, plus the two blend weights.
	function automatic void footprint(input logic [COORD_BITS-1:0] u, input logic [COORD_BITS-1:0] v,
			input logic [CFG_BITS-1:0] rw, input logic [CFG_BITS-1:0] rh,
			output logic [3:0][INDEX_BITS-1:0] taps, output int unsigned fx, output int unsigned fy);
		int unsigned w, h, x0, x1, y0, y1;
		w = eff_dim(rw, MAX_W);
		h = eff_dim(rh, MAX_H);
		split_axis(u, w, x0, x1, fx);
		split_axis(v, h, y0, y1, fy);
		taps[0] = INDEX_BITS'(y0 * w + x0);
		taps[1] = INDEX_BITS'(y0 * w + x1);
		taps[2] = INDEX_BITS'(y1 * w + x0);
		taps[3] = INDEX_BITS'(y1 * w + x1);
	endfunction

	// Expected pixel of one sample word, from the mirrored memory and dimensions.
	function automatic pixel_t blend_texels(input logic [COORD_BITS-1:0] u,
			input logic [COORD_BITS-1:0] v);
		logic [3:0][INDEX_BITS-1:0]          taps;
		logic [3:0][TEXEL_BITS-1:0]          tx;
		logic [NUM_CHAN-1:0][OUT_BITS-1:0]   chan;
		int unsigned                         fx, fy, one;
		longint unsigned                     w00, w10, w01, w11, sum;
		int                                  ch, k, sh;
		pixel_t                              px;
		footprint(u, v, mirror_w, mirror_h, taps, fx, fy);
		for (k = 0; k < 4; k++)
			tx[k] = texel_mirror[taps[k]];
		one = 1 << WGT_BITS;
		w00 = 64'(one - fx) * 64'(one - fy);
		w10 = 64'(fx) * 64'(one - fy);
		w01 = 64'(one - fx) * 64'(fy);
		w11 = 64'(fx) * 64'(fy);
		for (ch = 0; ch < NUM_CHAN; ch++) begin
			sh = 16 - 8 * ch;
			sum = w00 * 64'(tx[0][sh +: CHAN_BITS]) + w10 * 64'(tx[1][sh +: CHAN_BITS])
				+ w01 * 64'(tx[2][sh +: CHAN_BITS]) + w11 * 64'(tx[3][sh +: CHAN_BITS]);
			// 8.8 output: scale the weighted sum up by 256, then drop both weight fractions.
			chan[ch] = OUT_BITS'((sum << 8) >> (2 * WGT_BITS));
		end
		px.r = chan[0];
		px.g = chan[1];
		px.b = chan[2];
		return px;
	endfunction

	// Channel values lean toward the extremes now and then.
	function automatic logic [CHAN_BITS-1:0] rnd_chan();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return CHAN_BITS'($urandom_range(0, 255));
		endcase
	endfunction

	// Coordinates hit both borders often enough to exercise the edge clamp.
	function automatic logic [COORD_BITS-1:0] rnd_coord();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return COORD_BITS'($urandom_range(0, 65535));
		endcase
	endfunction

	// Mostly small textures, some large ones, and register values outside the legal range.
	function automatic logic [CFG_BITS-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return CFG_BITS'($urandom_range(1, 16));
			6, 7: return CFG_BITS'($urandom_range(17, 256));
			8: begin
				case ($urandom_range(0, 2))
					0: return 9'd0;
					1: return 9'd1;
					default: return 9'd256;
				endcase
			end
			default: return CFG_BITS'($urandom_range(257, 511));
		endcase
	endfunction

	task automatic plan_config(input logic sel, input logic [CFG_BITS-1:0] val);
		tex_op_t op;
		op = '0;
		op.is_cfg = 1'b1;
		op.reg_sel = sel;
		op.reg_val = val;
		texture_ops.push_back(op);
		if (sel == REG_TEX_WIDTH)
			plan_w = val;
		else
			plan_h = val;
	endtask

	task automatic plan_write(input logic [INDEX_BITS-1:0] idx, input logic [CHAN_BITS-1:0] r,
			input logic [CHAN_BITS-1:0] g, input logic [CHAN_BITS-1:0] b);
		tex_op_t op;
		op = '0;
		op.act = ACT_WRITE;
		op.index = idx;
		op.r = r;
		op.g = g;
		op.b = b;
		op.u = COORD_BITS'($urandom_range(0, 65535));
		op.v = COORD_BITS'($urandom_range(0, 65535));
		texture_ops.push_back(op);
		painted[idx] = 1'b1;
		n_items++;
	endtask

	// The memory is not cleared by reset, so any of the four texels that the plan has not
	// written yet gets a write of its own just ahead of the sample.
	task automatic plan_sample(input logic [COORD_BITS-1:0] u, input logic [COORD_BITS-1:0] v);
		logic [3:0][INDEX_BITS-1:0] taps;
		int unsigned                fx, fy;
		int                         k;
		tex_op_t                    op;
		footprint(u, v, plan_w, plan_h, taps, fx, fy);
		for (k = 0; k < 4; k++)
			if (!painted[taps[k]])
				plan_write(taps[k], rnd_chan(), rnd_chan(), rnd_chan());
		op = '0;
		op.act = ACT_SAMPLE;
		op.index = INDEX_BITS'($urandom_range(0, 65535));
		op.r = CHAN_BITS'($urandom_range(0, 255));
		op.g = CHAN_BITS'($urandom_range(0, 255));
		op.b = CHAN_BITS'($urandom_range(0, 255));
		op.u = u;
		op.v = v;
		texture_ops.push_back(op);
		n_items++;
	endtask

	// Driver. At each edge it first books whatever the block took (an item word or a register
	// write) into the predictor, then picks what goes on the ports next. Every port gets exactly
	// one nonblocking assignment per edge, so a start that stays high is never dropped and
	// raised in the same step.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
			gap_left = 0;
			burst_left = 0;
			idle_cycles = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_TEX_WIDTH)
					mirror_w = cfg_wdata;
				else
					mirror_h = cfg_wdata;
				n_cfg_writes++;
			end
			if (start && !busy) begin
				if (cur_op.act == ACT_WRITE) begin
					texel_mirror[cur_op.index] = {cur_op.r, cur_op.g, cur_op.b};
					n_texel_wr++;
				end else begin
					expected_pixels.push_back(blend_texels(cur_op.u, cur_op.v));
					n_samples++;
				end
				idle_cycles = 0;
			end else if (busy || expected_pixels.size() != 0) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end

			nxt_start = 1'b0;
			nxt_we = 1'b0;
			nxt_op = cur_op;
			if (start && busy) begin
				// The word has not been taken yet; keep it on the ports.
				nxt_start = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (texture_ops.size() == 0) begin
				feed_empty = 1'b1;
			end else if (texture_ops[0].is_cfg) begin
				// Dimension registers change only once the block has been quiet for a while.
				if (idle_cycles >= SETTLE_CYCLES) begin
					nxt_we = 1'b1;
					nxt_op = texture_ops.pop_front();
				end
			end else begin
				nxt_start = 1'b1;
				nxt_op = texture_ops.pop_front();
				// Bursts of random length, mostly short, sometimes long stretches with no gaps.
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					gap_left = $urandom_range(1, 13);
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 8);
				end
			end

			cur_op = nxt_op;
			start <= nxt_start;
			cfg_we <= nxt_we;
			action <= nxt_op.act;
			texel_index <= nxt_op.index;
			red_in <= nxt_op.r;
			green_in <= nxt_op.g;
			blue_in <= nxt_op.b;
			coord_u <= nxt_op.u;
			coord_v <= nxt_op.v;
			cfg_index <= nxt_op.reg_sel;
			cfg_wdata <= nxt_op.reg_val;
		end
	end

	// Monitor. A result is valid for the single cycle in which done is high, and is taken at the
	// edge that closes that cycle. Each one is checked against the oldest expected pixel.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("result %04h/%04h/%04h with no sample outstanding",
					red_out, green_out, blue_out));
			end else begin
				want_px = expected_pixels.pop_front();
				if (red_out !== want_px.r)
					report_mismatch($sformatf("result %0d red %04h, expected %04h",
						n_results, red_out, want_px.r));
				if (green_out !== want_px.g)
					report_mismatch($sformatf("result %0d green %04h, expected %04h",
						n_results, green_out, want_px.g));
				if (blue_out !== want_px.b)
					report_mismatch($sformatf("result %0d blue %04h, expected %04h",
						n_results, blue_out, want_px.b));
			end
			n_results++;
		end
	end

	// Plan the whole run, release reset, then wait for the last result.
	initial begin : main_seq
		int          phase_ops;
		int          roll;
		int unsigned area;
		pixel_t      left_px;

		// Directed part, still at the reset dimensions of 256 by 256.
		// A full-scale texel sampled exactly on its center gives the largest output,
		// a black one the smallest.
		plan_write(16'h0000, 8'hFF, 8'hFF, 8'hFF);
		plan_sample(16'h0000, 16'h0000);
		plan_write(16'h0000, 8'h00, 8'h00, 8'h00);
		plan_sample(16'h0000, 16'h0000);
		// Bottom-right corner: both neighbors clamp and lose their weight.
		plan_sample(16'hFFFF, 16'hFFFF);
		// Half-texel horizontal fraction at the left edge, halfway down the texture.
		plan_sample(16'h0080, 16'h8000);
		// Address bits in both patterns.
		plan_write(16'h5555, 8'hA5, 8'h5A, 8'hFF);
		plan_write(16'hAAAA, 8'h5A, 8'hA5, 8'h00);
		// A single-texel texture: every sample reads texel zero alone.
		plan_config(REG_TEX_WIDTH, 9'd1);
		plan_config(REG_TEX_HEIGHT, 9'd1);
		plan_sample(16'h7FFF, 16'hC001);
		// A zero width acts as one and an oversized height as the maximum.
		plan_config(REG_TEX_WIDTH, 9'd0);
		plan_config(REG_TEX_HEIGHT, 9'd300);
		plan_sample(16'h1234, 16'hFFFF);
		// All-ones width acts as the maximum; zero height acts as one.
		plan_config(REG_TEX_WIDTH, 9'd511);
		plan_config(REG_TEX_HEIGHT, 9'd0);
		plan_sample(16'hFFFF, 16'h4000);
		plan_sample(16'h8080, 16'h0000);

		// Random part: phases with fresh dimensions, each a mix of samples, in-texture writes
		// that change what later samples see, and writes anywhere in the memory.
		while (n_items < ITEM_TARGET) begin
			if ($urandom_range(0, 1) == 0) begin
				plan_config(REG_TEX_WIDTH, pick_dim());
				plan_config(REG_TEX_HEIGHT, pick_dim());
			end else begin
				plan_config(REG_TEX_HEIGHT, pick_dim());
				plan_config(REG_TEX_WIDTH, pick_dim());
			end
			area = eff_dim(plan_w, MAX_W) * eff_dim(plan_h, MAX_H);
			phase_ops = $urandom_range(15, 60);
			repeat (phase_ops) begin
				roll = $urandom_range(0, 99);
				if (roll < 65)
					plan_sample(rnd_coord(), rnd_coord());
				else if (roll < 85)
					plan_write(INDEX_BITS'($urandom_range(0, area - 1)),
						rnd_chan(), rnd_chan(), rnd_chan());
				else
					plan_write(INDEX_BITS'($urandom_range(0, 65535)),
						rnd_chan(), rnd_chan(), rnd_chan());
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		wait (feed_empty);
		for (drain_wait = 0; drain_wait < 200 && expected_pixels.size() != 0; drain_wait++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (expected_pixels.size() != 0) begin
			left_px = expected_pixels.pop_front();
			report_mismatch($sformatf("expected pixel %04h/%04h/%04h never arrived",
				left_px.r, left_px.g, left_px.b));
		end

		$display("Run covered %0d samples and %0d texel writes over %0d dimension register writes.",
			n_samples, n_texel_wr, n_cfg_writes);
		$display("%0d results compared, %0d mismatches.", n_results, n_errors);
		if (n_errors == 0)
			$display("bilinear_texture_sampler verification clean");
		else
			$display("bilinear_texture_sampler verification failed");
		$finish;
	end

	// Hang guard, several times the longest legal run.
	initial begin
		#4000000;
		$display("bilinear_texture_sampler verification failed");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/bts_pkg.sv
hw/rtl/bts_ram.sv
hw/rtl/bts_blend.sv
hw/rtl/bilinear_texture_sampler.sv
tb/sv/bilinear_texture_sampler_tb.sv
